// ----- hdl/aov_pkg.sv -----
`default_nettype none

package aov_pkg;

  localparam int CoordWidth = 32;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int PushWidth  = CoordWidth + 2;
  localparam int NumAxes    = 3;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic        [DiffWidth-1:0]  mag_t;
  typedef logic signed [PushWidth-1:0]  push_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Magnitudes of both Minkowski bounds per axis, with the overlap flag.
  typedef struct packed {
    logic                    hit;
    logic [NumAxes-1:0][DiffWidth-1:0] mag_lo;
    logic [NumAxes-1:0][DiffWidth-1:0] mag_hi;
  } mag_set_t;

endpackage

`default_nettype wire

// ----- hdl/aov_if.sv -----
`default_nettype none

interface aov_box_if;
  logic           valid;
  logic           ready;
  aov_pkg::coord_t a_min_x;
  aov_pkg::coord_t a_min_y;
  aov_pkg::coord_t a_min_z;
  aov_pkg::coord_t a_max_x;
  aov_pkg::coord_t a_max_y;
  aov_pkg::coord_t a_max_z;
  aov_pkg::coord_t b_min_x;
  aov_pkg::coord_t b_min_y;
  aov_pkg::coord_t b_min_z;
  aov_pkg::coord_t b_max_x;
  aov_pkg::coord_t b_max_y;
  aov_pkg::coord_t b_max_z;

  modport source (
    output valid, a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
           b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z,
    input  ready
  );
  modport sink (
    input  valid, a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
           b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z,
    output ready
  );
endinterface

interface aov_push_if;
  logic           valid;
  logic           ready;
  logic           hit;
  aov_pkg::push_t push_x;
  aov_pkg::push_t push_y;
  aov_pkg::push_t push_z;

  modport source (output valid, hit, push_x, push_y, push_z, input ready);
  modport sink   (input  valid, hit, push_x, push_y, push_z, output ready);
endinterface

`default_nettype wire

// ----- hdl/aov_diff.sv -----
`default_nettype none

// Stages 1 and 2: Minkowski bounds, then their magnitudes and the overlap flag.
module aov_diff (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              in_valid,
  input  wire aov_pkg::coord_t   a_min [aov_pkg::NumAxes],
  input  wire aov_pkg::coord_t   a_max [aov_pkg::NumAxes],
  input  wire aov_pkg::coord_t   b_min [aov_pkg::NumAxes],
  input  wire aov_pkg::coord_t   b_max [aov_pkg::NumAxes],
  output logic                   out_valid,
  output aov_pkg::mag_set_t      out_mags
);

  logic           s1_valid;
  aov_pkg::diff_t s1_lo [aov_pkg::NumAxes];
  aov_pkg::diff_t s1_hi [aov_pkg::NumAxes];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int ax = 0; ax < aov_pkg::NumAxes; ax++) begin
        s1_lo[ax] <= {a_min[ax][aov_pkg::CoordWidth-1], a_min[ax]}
                   - {b_max[ax][aov_pkg::CoordWidth-1], b_max[ax]};
        s1_hi[ax] <= {a_max[ax][aov_pkg::CoordWidth-1], a_max[ax]}
                   - {b_min[ax][aov_pkg::CoordWidth-1], b_min[ax]};
      end
    end
  end

  logic hit_all;

  always_comb begin
    hit_all = 1'b1;
    for (int ax = 0; ax < aov_pkg::NumAxes; ax++) begin
      if (s1_lo[ax] > 0 || s1_hi[ax] < 0) begin
        hit_all = 1'b0;
      end
    end
  end

  // The most negative bound, -2^32 + 1, negates to 2^32 - 1, which the unsigned
  // magnitude still holds.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_mags.hit <= hit_all;
      for (int ax = 0; ax < aov_pkg::NumAxes; ax++) begin
        out_mags.mag_lo[ax] <= s1_lo[ax][aov_pkg::DiffWidth-1] ?
                               aov_pkg::mag_t'(-s1_lo[ax]) : aov_pkg::mag_t'(s1_lo[ax]);
        out_mags.mag_hi[ax] <= s1_hi[ax][aov_pkg::DiffWidth-1] ?
                               aov_pkg::mag_t'(-s1_hi[ax]) : aov_pkg::mag_t'(s1_hi[ax]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/aov_select.sv -----
`default_nettype none

// Stages 3 to 5: smallest magnitude per axis, then across axes, then the push.
// Every compare uses <= so that the earlier candidate wins a tie.
module aov_select (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              in_valid,
  input  wire aov_pkg::mag_set_t in_mags,
  output logic                   out_valid,
  output logic                   out_hit,
  output aov_pkg::push_t         out_push_x,
  output aov_pkg::push_t         out_push_y,
  output aov_pkg::push_t         out_push_z
);

  logic          s3_valid;
  logic          s3_hit;
  aov_pkg::mag_t s3_mag [aov_pkg::NumAxes];
  logic          s3_low [aov_pkg::NumAxes];

  logic          s4_valid;
  logic          s4_hit;
  aov_pkg::mag_t s4_mag_xy;
  logic          s4_low_xy;
  aov_pkg::axis_t s4_axis_xy;
  aov_pkg::mag_t s4_mag_z;
  logic          s4_low_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s3_valid  <= in_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_hit <= in_mags.hit;
      for (int ax = 0; ax < aov_pkg::NumAxes; ax++) begin
        if (in_mags.mag_lo[ax] <= in_mags.mag_hi[ax]) begin
          s3_mag[ax] <= in_mags.mag_lo[ax];
          s3_low[ax] <= 1'b1;
        end else begin
          s3_mag[ax] <= in_mags.mag_hi[ax];
          s3_low[ax] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_hit   <= s3_hit;
      s4_mag_z <= s3_mag[2];
      s4_low_z <= s3_low[2];
      if (s3_mag[0] <= s3_mag[1]) begin
        s4_mag_xy  <= s3_mag[0];
        s4_low_xy  <= s3_low[0];
        s4_axis_xy <= aov_pkg::AXIS_X;
      end else begin
        s4_mag_xy  <= s3_mag[1];
        s4_low_xy  <= s3_low[1];
        s4_axis_xy <= aov_pkg::AXIS_Y;
      end
    end
  end

  aov_pkg::mag_t  best_mag;
  logic           best_low;
  aov_pkg::axis_t best_axis;
  aov_pkg::push_t best_push;

  // A low bound is never positive, so its negation is +magnitude; a high
  // bound is never negative, so its negation is -magnitude.
  always_comb begin
    if (s4_mag_xy <= s4_mag_z) begin
      best_mag  = s4_mag_xy;
      best_low  = s4_low_xy;
      best_axis = s4_axis_xy;
    end else begin
      best_mag  = s4_mag_z;
      best_low  = s4_low_z;
      best_axis = aov_pkg::AXIS_Z;
    end
    best_push = best_low ? aov_pkg::push_t'({1'b0, best_mag})
                         : -aov_pkg::push_t'({1'b0, best_mag});
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit    <= s4_hit;
      out_push_x <= '0;
      out_push_y <= '0;
      out_push_z <= '0;
      if (s4_hit) begin
        unique case (best_axis)
          aov_pkg::AXIS_X: out_push_x <= best_push;
          aov_pkg::AXIS_Y: out_push_y <= best_push;
          aov_pkg::AXIS_Z: out_push_z <= best_push;
          default:         out_push_x <= '0;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/aabb_overlap_push_vector.sv -----
`default_nettype none

// Box overlap test with minimum push vector. Each transaction on box_in carries
// the min and max corners of boxes A and B in signed Q16.16; the matching
// transaction on push_out gives the hit flag and the push vector in signed
// Q18.16, zero on the axes not chosen and zero everywhere on a miss. The block
// is a five-stage pipeline (bounds, magnitudes, per-axis minimum, x/y minimum,
// final minimum and push) that takes one box pair per cycle unless it holds.
// The whole pipeline holds while the output register has a result that
// push_out does not take; box_in.ready then falls, and no result is lost or
// repeated.
module aabb_overlap_push_vector (
  input  wire logic   clk,
  input  wire logic   rst,
  aov_box_if.sink     box_in,
  aov_push_if.source  push_out
);

  logic              advance;
  logic              mags_valid;
  aov_pkg::mag_set_t mags;

  aov_pkg::coord_t a_min [aov_pkg::NumAxes];
  aov_pkg::coord_t a_max [aov_pkg::NumAxes];
  aov_pkg::coord_t b_min [aov_pkg::NumAxes];
  aov_pkg::coord_t b_max [aov_pkg::NumAxes];

  assign advance      = !push_out.valid || push_out.ready;
  assign box_in.ready = advance;

  assign a_min[0] = box_in.a_min_x;
  assign a_min[1] = box_in.a_min_y;
  assign a_min[2] = box_in.a_min_z;
  assign a_max[0] = box_in.a_max_x;
  assign a_max[1] = box_in.a_max_y;
  assign a_max[2] = box_in.a_max_z;
  assign b_min[0] = box_in.b_min_x;
  assign b_min[1] = box_in.b_min_y;
  assign b_min[2] = box_in.b_min_z;
  assign b_max[0] = box_in.b_max_x;
  assign b_max[1] = box_in.b_max_y;
  assign b_max[2] = box_in.b_max_z;

  aov_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (box_in.valid),
    .a_min     (a_min),
    .a_max     (a_max),
    .b_min     (b_min),
    .b_max     (b_max),
    .out_valid (mags_valid),
    .out_mags  (mags)
  );

  aov_select u_select (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (mags_valid),
    .in_mags    (mags),
    .out_valid  (push_out.valid),
    .out_hit    (push_out.hit),
    .out_push_x (push_out.push_x),
    .out_push_y (push_out.push_y),
    .out_push_z (push_out.push_z)
  );

endmodule

`default_nettype wire
